// File: design/brt_pkg.sv
// Shared types and constants for the byte-rate throttle.
// Field widths, action and status codes, item structs and control structs.
// No dependencies.
package brt_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int NOW_W         = 48;
  localparam int BYTES_W       = 40;
  localparam int TMO_W         = 32;
  localparam int LIMIT_W       = 41;
  localparam int SCALE_W       = 20;
  localparam int PROD_W        = BYTES_W + SCALE_W;
  localparam int TMO_US_W      = TMO_W + 10;

  localparam logic [SCALE_W-1:0] US_PER_S  = 20'd1000000;
  localparam logic [9:0]         US_PER_MS = 10'd1000;

  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_TRY    = 2'd1;
  localparam logic [1:0] ACT_ACQ    = 2'd2;

  localparam logic [1:0] ST_NOW      = 2'd0;
  localparam logic [1:0] ST_WAITED   = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;
  localparam logic [1:0] ST_RECORDED = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [NOW_W-1:0]   now_us;
    logic [BYTES_W-1:0] xfer_bytes;
    logic [TMO_W-1:0]   timeout_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [NOW_W-1:0] ready_time_us;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rec_go;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// File: design/brt_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Used by brt_dp for the transfer cost; no package dependency.
module brt_div #(
  parameter int N_W = 60,
  parameter int D_W = 40
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [N_W-1:0]   quo_r, quo_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   dvs_r, dvs_nxt;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             ge;

  always_comb begin
    trial    = {rem_r, quo_r[N_W-1]};
    ge       = trial >= {1'b0, dvs_r};
    diff     = trial - {1'b0, dvs_r};
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = CNT_W'(N_W);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      quo_nxt  = {quo_r[N_W-2:0], ge};
      rem_nxt  = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: design/brt_dp.sv
// Datapath: limit register, next-permitted time, item registers, deadline,
// cost division and saturating advance, output register. Uses brt_pkg, brt_div.
module brt_dp
  import brt_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  in_item_t            in_data,
  input  logic                cfg_valid,
  input  logic [LIMIT_W-1:0]  cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data
);

  localparam int DL_W  = ((TIME_BITS > TMO_US_W) ? TIME_BITS : TMO_US_W) + 1;
  localparam int SUM_W = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;
  localparam logic [63:0] TMAX64 = (64'd1 << TIME_BITS) - 64'd1;

  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [TIME_BITS-1:0] next_r, next_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [1:0]           act_r, act_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [TMO_US_W-1:0]  tmo_us_r, tmo_us_nxt;
  logic [TIME_BITS-1:0] base_r, base_nxt;
  logic [1:0]           status_r, status_nxt;

  logic [TIME_BITS+NOW_W-1:0] now_ext;
  logic                 lim_neg, grant, past;
  logic [DL_W-1:0]      deadline;
  logic                 div_done;
  logic [PROD_W-1:0]    quo;
  logic [PROD_W-1:0]    cost;
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] ready;
  logic [TIME_BITS+NOW_W-1:0] ready_ext;

  brt_div #(
    .N_W(PROD_W),
    .D_W(LIMIT_W - 1)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (limit_r[LIMIT_W-2:0]),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    now_ext   = {{TIME_BITS{1'b0}}, in_data.now_us};
    lim_neg   = limit_r[LIMIT_W-1];
    past      = now_r > next_r;
    grant     = lim_neg || past;
    deadline  = DL_W'(now_r) + DL_W'(tmo_us_r);
    cost      = (quo == '0) ? PROD_W'(1) : quo;
    sum       = SUM_W'(base_r) + SUM_W'(cost);
    ready     = (next_r == '1) ? next_r : next_r + 1'b1;
    ready_ext = {{NOW_W{1'b0}}, ready};

    stat.rec_go   = (act_r == ACT_RECORD) && !lim_neg && (limit_r != '0) && (prod_r != '0);
    stat.div_done = div_done;
    stat.out_free = !out_valid_r || !out_stall;

    limit_nxt     = cfg_valid ? cfg_data : limit_r;
    act_nxt       = act_r;
    now_nxt       = now_r;
    prod_nxt      = prod_r;
    tmo_us_nxt    = tmo_us_r;
    base_nxt      = base_r;
    status_nxt    = status_r;
    next_nxt      = next_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.load) begin
      act_nxt    = in_data.action;
      now_nxt    = now_ext[TIME_BITS-1:0];
      prod_nxt   = PROD_W'(in_data.xfer_bytes) * PROD_W'(US_PER_S);
      tmo_us_nxt = TMO_US_W'(in_data.timeout_ms) * TMO_US_W'(US_PER_MS);
    end

    if (cmd.eval) begin
      base_nxt = past ? now_r : next_r;
      unique case (act_r)
        ACT_TRY: status_nxt = grant ? ST_NOW : ST_TIMEOUT;
        ACT_ACQ: begin
          if (grant) begin
            status_nxt = ST_NOW;
          end else if (tmo_us_r != '0 && deadline <= DL_W'(next_r)) begin
            status_nxt = ST_TIMEOUT;
          end else begin
            status_nxt = ST_WAITED;
          end
        end
        default: status_nxt = ST_RECORDED;
      endcase
    end

    if (cmd.add) begin
      next_nxt = (sum > SUM_W'(TMAX64)) ? TIME_BITS'(TMAX64) : sum[TIME_BITS-1:0];
    end

    if (cmd.out_load) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.status        = status_r;
      out_data_nxt.ready_time_us = ready_ext[NOW_W-1:0];
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= '1;
      next_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    now_r      <= now_nxt;
    prod_r     <= prod_nxt;
    tmo_us_r   <= tmo_us_nxt;
    base_r     <= base_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/brt_ctrl.sv
// Controller FSM: sequences accept, evaluate, divide, advance and output.
// Uses brt_pkg command and status structs.
module brt_ctrl
  import brt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.rec_go) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/byte_rate_io_throttle.sv
// Byte-rate throttle top level: one next-permitted time, limit register.
// Record beat with a finite nonzero limit and nonzero bytes: after accept, evaluate,
// 60-step serial divide and its done flag, advance, output load. Other beats: evaluate,
// then output load. One beat in flight: no new beat is accepted until the last is loaded
// to the output; a held result delays the next output load until it is taken.
// Synchronous active-low reset: next time 0, limit -1 (unlimited), output empty.
module byte_rate_io_throttle
  import brt_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  brt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  brt_dp #(
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/byte_rate_io_throttle_tb.sv
// Testbench for byte_rate_io_throttle: directed and random beats checked against
// an in-bench predictor of the next permitted time, with random stalls on both sides.
// Depends on brt_pkg and byte_rate_io_throttle.
`timescale 1ns / 1ps

module byte_rate_io_throttle_tb;
  import brt_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [NOW_W-1:0] TIME_MAX = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
  localparam logic [TMO_W-1:0] TMO_MAX = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_UNLIMITED = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = {1'b0, {(LIMIT_W-1){1'b1}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  logic [NOW_W-1:0] allow_at_us = '0;
  logic [LIMIT_W-1:0] rate_limit = LIMIT_UNLIMITED;
  logic [NOW_W-1:0] clock_us = '0;
  out_item_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int n_errors = 0;
  int n_beats = 0;
  int n_records = 0;
  int n_now = 0;
  int n_waited = 0;
  int n_refused = 0;
  int n_limits = 0;

  byte_rate_io_throttle DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic out_item_t predict_throttle(in_item_t it);
    logic [63:0] cost;
    logic [63:0] deadline;
    logic unlimited;
    out_item_t r;
    unlimited = rate_limit[LIMIT_W-1];
    r.status = ST_RECORDED;
    case (it.action)
      ACT_RECORD: begin
        if (!unlimited && rate_limit != '0 && it.xfer_bytes != '0) begin
          cost = (64'(it.xfer_bytes) * 64'(US_PER_S)) / 64'(rate_limit);
          if (cost == 64'd0) cost = 64'd1;
          if (it.now_us > allow_at_us) allow_at_us = it.now_us;
          if (cost > 64'(TIME_MAX - allow_at_us)) allow_at_us = TIME_MAX;
          else allow_at_us = allow_at_us + cost[NOW_W-1:0];
        end
      end
      ACT_TRY: begin
        r.status = (unlimited || it.now_us > allow_at_us) ? ST_NOW : ST_TIMEOUT;
      end
      ACT_ACQ: begin
        if (unlimited || it.now_us > allow_at_us) begin
          r.status = ST_NOW;
        end else if (it.timeout_ms != '0) begin
          deadline = 64'(it.now_us) + 64'(it.timeout_ms) * 64'(US_PER_MS);
          r.status = (deadline <= 64'(allow_at_us)) ? ST_TIMEOUT : ST_WAITED;
        end else begin
          r.status = ST_WAITED;
        end
      end
      default: ;
    endcase
    r.ready_time_us = (allow_at_us == TIME_MAX) ? TIME_MAX : allow_at_us + 1'b1;
    n_beats++;
    case (r.status)
      ST_NOW: n_now++;
      ST_WAITED: n_waited++;
      ST_TIMEOUT: n_refused++;
      default: n_records++;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_beat(logic [1:0] act, logic [NOW_W-1:0] now,
                                         logic [BYTES_W-1:0] bytes, logic [TMO_W-1:0] tmo);
    in_item_t it;
    it.action = act;
    it.now_us = now;
    it.xfer_bytes = bytes;
    it.timeout_ms = tmo;
    return it;
  endfunction

  // Traffic beats: the bench clock moves forward, costs and timeouts sized around the limit
  function automatic in_item_t gen_traffic_beat();
    logic [1:0] act;
    logic [NOW_W-1:0] now;
    logic [BYTES_W-1:0] bytes;
    logic [TMO_W-1:0] tmo;
    logic [63:0] target;
    logic [63:0] gap_ms;
    int r;
    r = $urandom_range(0, 99);
    clock_us = clock_us + NOW_W'($urandom_range(0, 4000));
    now = clock_us;
    if ($urandom_range(0, 3) == 0 && allow_at_us > 48'd2) begin
      now = allow_at_us + NOW_W'($urandom_range(0, 4)) - 48'd2;
      if (now > clock_us) clock_us = now;
    end
    if (r < 35) act = ACT_RECORD;
    else if (r < 60) act = ACT_TRY;
    else if (r < 96) act = ACT_ACQ;
    else act = ACT_UNUSED;
    bytes = '0;
    target = 64'($urandom_range(1, 8000));
    if ($urandom_range(0, 11) != 0) begin
      if (rate_limit[LIMIT_W-1] || rate_limit == '0)
        bytes = BYTES_W'($urandom_range(1, 1000000));
      else
        bytes = BYTES_W'((target * 64'(rate_limit)) / 64'(US_PER_S)
                         + 64'($urandom_range(0, 3)));
    end
    gap_ms = (allow_at_us > now) ? 64'(allow_at_us - now) / 64'(US_PER_MS) : 64'd0;
    case ($urandom_range(0, 2))
      0: tmo = '0;
      1: tmo = TMO_W'(gap_ms) + TMO_W'($urandom_range(0, 2));
      default: tmo = TMO_W'($urandom_range(1, 60));
    endcase
    return make_beat(act, now, bytes, tmo);
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return LIMIT_W'(1000000);
      1: return LIMIT_W'($urandom_range(1000, 5000000));
      2: return LIMIT_W'({8'($urandom_range(0, 255)), 32'($urandom)}) | LIMIT_W'(1);
      3: return '0;
      4: return LIMIT_UNLIMITED;
      default: return LIMIT_W'($urandom_range(100000, 2000000));
    endcase
  endfunction

  task automatic send_beat(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_throttle(it));
  endtask

  task automatic park_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    park_sender();
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    rate_limit = value;
    n_limits++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // unlimited after reset
    send_beat(make_beat(ACT_TRY, 48'd0, 40'd0, 32'd0));
    send_beat(make_beat(ACT_ACQ, 48'd0, 40'd0, 32'd0));
    send_beat(make_beat(ACT_RECORD, 48'd5, 40'd1000, 32'd0));
    send_beat(make_beat(ACT_UNUSED, 48'd0, 40'd0, 32'd0));
    // frozen rate
    write_limit('0);
    send_beat(make_beat(ACT_RECORD, 48'd10, 40'd500, 32'd0));
    send_beat(make_beat(ACT_TRY, 48'd0, 40'd0, 32'd0));
    send_beat(make_beat(ACT_ACQ, 48'd0, 40'd0, 32'd0));
    send_beat(make_beat(ACT_ACQ, 48'd0, 40'd0, 32'd1));
    send_beat(make_beat(ACT_TRY, 48'd1, 40'd0, 32'd0));
    write_limit(LIMIT_W'(1000000));
    send_beat(make_beat(ACT_RECORD, 48'd2000, 40'd0, 32'd0));
    send_beat(make_beat(ACT_RECORD, 48'd2000, 40'd5000, 32'd0));
    send_beat(make_beat(ACT_TRY, 48'd7000, 40'd0, 32'd0));
    send_beat(make_beat(ACT_TRY, 48'd7001, 40'd0, 32'd0));
    send_beat(make_beat(ACT_ACQ, 48'd3000, 40'd0, 32'd4));
    send_beat(make_beat(ACT_ACQ, 48'd3000, 40'd0, 32'd5));
    send_beat(make_beat(ACT_ACQ, 48'd3000, 40'd0, TMO_MAX));
    send_beat(make_beat(ACT_ACQ, 48'd3000, 40'd0, 32'd0));
    send_beat(make_beat(ACT_RECORD, 48'd1000, 40'd1, 32'd0));
    // cost rounds to zero, then the largest transfer
    write_limit(LIMIT_MAX);
    send_beat(make_beat(ACT_RECORD, 48'd100, 40'd1, 32'd0));
    send_beat(make_beat(ACT_RECORD, 48'd100, BYTES_MAX, 32'd0));
    write_limit(LIMIT_W'(1));
    send_beat(make_beat(ACT_RECORD, 48'd100, 40'd1, 32'd0));
    send_beat(make_beat(ACT_UNUSED, TIME_MAX, BYTES_MAX, TMO_MAX));
    clock_us = allow_at_us;
  endtask

  task automatic test_backpressure();
    write_limit(LIMIT_W'(1000000));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_left = 300;
    repeat (40) send_beat(gen_traffic_beat());
    park_sender();
    drain_results();
    repeat (20) send_beat(gen_traffic_beat());
  endtask

  task automatic test_random_traffic(input int n, input int sp, input int rp);
    int k;
    for (k = 0; k < n; k++) begin
      if (k % (n / 4) == 0) write_limit(pick_limit());
      send_idle_pct = sp;
      recv_idle_pct = rp;
      send_beat(gen_traffic_beat());
    end
  endtask

  // Full-range fields; the limit keeps the next permitted time where it is
  task automatic test_unlimited_noise();
    int k;
    send_idle_pct = 10;
    recv_idle_pct = 10;
    for (k = 0; k < 60; k++) begin
      if (k == 0) write_limit(LIMIT_UNLIMITED);
      if (k == 30) write_limit('0);
      send_beat(make_beat(2'($urandom_range(0, 3)),
                          NOW_W'({16'($urandom), 32'($urandom)}),
                          BYTES_W'({8'($urandom), 32'($urandom)}),
                          TMO_W'($urandom)));
    end
  endtask

  task automatic test_saturation();
    write_limit(LIMIT_W'(1000000));
    send_beat(make_beat(ACT_RECORD, TIME_MAX - 48'd10, BYTES_MAX, 32'd0));
    send_beat(make_beat(ACT_TRY, TIME_MAX, 40'd0, 32'd0));
    send_beat(make_beat(ACT_ACQ, TIME_MAX, 40'd0, TMO_MAX));
    send_beat(make_beat(ACT_ACQ, TIME_MAX - 48'd1000000, 40'd0, 32'd1000));
    send_beat(make_beat(ACT_ACQ, TIME_MAX - 48'd1000000, 40'd0, 32'd0));
    send_beat(make_beat(ACT_RECORD, 48'd0, 40'd1, 32'd0));
    write_limit(LIMIT_UNLIMITED);
    send_beat(make_beat(ACT_TRY, 48'd0, 40'd0, 32'd0));
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d ready_time_us %0d",
               out_data.status, out_data.ready_time_us);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
          n_errors++;
        end
        if (out_data.ready_time_us !== want.ready_time_us) begin
          $error("ready_time_us mismatch: expected %0d, actual %0d",
                 want.ready_time_us, out_data.ready_time_us);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_traffic(400, 29, 69);
    test_random_traffic(400, 69, 29);
    test_random_traffic(400, 0, 0);
    test_unlimited_noise();
    test_saturation();
    park_sender();
    drain_results();
    repeat (80) @(posedge clk);
    $display("%0d beats over %0d limit writes: %0d recorded, %0d granted now,",
             n_beats, n_limits, n_records, n_now);
    $display("%0d granted after wait, %0d refused or timed out", n_waited, n_refused);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
design/brt_pkg.sv
design/brt_div.sv
design/brt_dp.sv
design/brt_ctrl.sv
design/byte_rate_io_throttle.sv
tb/byte_rate_io_throttle_tb.sv
